// File: rtl/lru_event_dedup_throttle_unit_macros.svh
// Assertion macros shared by the RTL of the event dedup throttle unit.
// Every macro names its clock and reset and stays quiet while reset is high.
`ifndef LRU_EVENT_DEDUP_THROTTLE_UNIT_MACROS_SVH
`define LRU_EVENT_DEDUP_THROTTLE_UNIT_MACROS_SVH

// Check that an expression holds at every clock edge.
`define LRUDT_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define LRUDT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define LRUDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/lrudt_pkg.sv
// ----------------------------------------------------------------------------
// lrudt_pkg
// Types and constants of the event dedup throttle unit: table entry layout,
// cell control bundle, sequencer states and register indexes.
// ----------------------------------------------------------------------------
package lrudt_pkg;

   localparam int FAMILY_W = 16;
   localparam int CODE_W   = 32;
   localparam int SITE_W   = 32;
   localparam int TIME_W   = 48;
   localparam int HITS_W   = 32;
   localparam int WINDOW_W = 32;
   localparam int LIMIT_W  = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = FAMILY_W + CODE_W + SITE_W + TIME_W;
   localparam int RSP_DATA_W = HITS_W;

   localparam logic [HITS_W-1:0]   HITS_MAX     = '1;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd30000;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd100;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_WINDOW = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BURST_LIMIT   = 8'd1;

   typedef struct packed {
      logic [SITE_W-1:0]   site;
      logic [CODE_W-1:0]   code;
      logic [FAMILY_W-1:0] family;
   } key_type;

   typedef struct packed {
      key_type             key;
      logic [HITS_W-1:0]   hits;
      logic [TIME_W-1:0]   last_time;
      logic [HITS_W-1:0]   at_last;
   } entry_type;

   // Broadcast from the sequencer to every cell
   typedef struct packed {
      logic    capture;   // latch tag compare result
      logic    update;    // apply move-to-front shift
      logic    hit_found; // some cell matched
      key_type key;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PICK,
      ST_DECIDE
   } state_type;

endpackage

// File: rtl/lrudt_cell.sv
// ----------------------------------------------------------------------------
// lrudt_cell
// One slot of the recency table. Compares its tag against the broadcast key,
// passes the hit seen flag and the selected entry toward the front, and takes
// its neighbor's entry on a move-to-front shift.
// ----------------------------------------------------------------------------
module lrudt_cell
   import lrudt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic         up_valid,   // neighbor toward the front
   input  entry_type    up_entry,
   output logic         own_valid,
   output entry_type    own_entry,
   input  logic         seen_in,    // match at a later slot
   output logic         seen_out,
   input  entry_type    sel_in,     // matched entry from later slots
   output entry_type    sel_out,
   output logic         match_out
);

   logic      valid_ff, valid_in;
   logic      match_ff, match_in;
   entry_type entry_ff, entry_in;
   logic      tag_eq;
   logic      shift_here;

   // Compare stored tag with the incoming key
   assign tag_eq   = valid_ff && (entry_ff.key == ctl.key);

   // Slot moves when it lies at or before the hit, or on any miss
   assign seen_out   = seen_in | match_ff;
   assign shift_here = ctl.update && (!ctl.hit_found || seen_out);

   assign sel_out   = entry_type'(sel_in | (match_ff ? entry_ff : '0));
   assign own_valid = valid_ff;
   assign own_entry = entry_ff;
   assign match_out = match_ff;

   // Next state of the slot
   always_comb begin
      match_in = ctl.capture ? tag_eq : match_ff;
      valid_in = shift_here ? up_valid : valid_ff;
      entry_in = shift_here ? up_entry : entry_ff;
   end

   // Control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   // Slot payload
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: rtl/lru_event_dedup_throttle_unit.sv
// Flow: an accepted event goes through the select and decide states, and its result
// is registered on decide; events pass one at a time (accept and tag compare, select,
// decide), set by the one-at-a-time sequencer over the cell chain.
// A waiting result does not block the next accept; decide holds until it drains.
// Reset: synchronous; empties the table, restores repeat_window 30000 and
// burst_limit 100, and clears the result valid flag.
// ----------------------------------------------------------------------------
// lru_event_dedup_throttle_unit
// Deduplicates and rate-limits error events with a move-to-front table built
// as a chain of cells.
// ----------------------------------------------------------------------------
`include "lru_event_dedup_throttle_unit_macros.svh"

module lru_event_dedup_throttle_unit
   import lrudt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // event in
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // family_tag[15:0], error_code[47:16], site_tag[79:48], now_ticks[127:80]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // result out
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // repeat_count[31:0]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // full_flag[0]
   output logic                  rsp_tuser,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int N = TABLE_ENTRIES;

   state_type state_ff, state_in;

   logic [WINDOW_W-1:0] window_ff, window_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;

   key_type            key_ff, key_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   entry_type          sel_ff, sel_in;
   logic               hit_ff, hit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [HITS_W-1:0]  rsp_count_ff, rsp_count_in;
   logic               rsp_full_ff, rsp_full_in;

   cell_ctl_type       ctl;
   key_type            req_key;
   logic               req_fire;
   logic               decide_go;

   entry_type          front_entry;
   entry_type          entry_chain [N];
   logic [N-1:0]       valid_vec;
   logic [N-1:0]       match_vec;
   logic [N:0]         seen_chain;
   entry_type          sel_chain [N+1];

   logic [HITS_W-1:0]  hits_next;
   logic [TIME_W-1:0]  elapsed;
   logic [HITS_W:0]    burst;
   logic               hit_full;

   // Unpack incoming key
   assign req_key.family = req_tdata[FAMILY_W-1:0];
   assign req_key.code   = req_tdata[FAMILY_W+CODE_W-1:FAMILY_W];
   assign req_key.site   = req_tdata[FAMILY_W+CODE_W+SITE_W-1:FAMILY_W+CODE_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign decide_go  = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_tready);

   // Broadcast to the cells
   assign ctl.capture   = req_fire;
   assign ctl.update    = decide_go;
   assign ctl.hit_found = hit_ff;
   assign ctl.key       = req_key;

   // Chain ends
   assign seen_chain[N] = 1'b0;
   assign sel_chain[N]  = '0;

   // Row of table cells, slot 0 most recent
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic      up_valid;
      entry_type up_entry;
      if (i == 0) begin : g_front
         assign up_valid = 1'b1;
         assign up_entry = front_entry;
      end else begin : g_rest
         assign up_valid = valid_vec[i-1];
         assign up_entry = entry_chain[i-1];
      end
      lrudt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .up_valid  (up_valid),
         .up_entry  (up_entry),
         .own_valid (valid_vec[i]),
         .own_entry (entry_chain[i]),
         .seen_in   (seen_chain[i+1]),
         .seen_out  (seen_chain[i]),
         .sel_in    (sel_chain[i+1]),
         .sel_out   (sel_chain[i]),
         .match_out (match_vec[i])
      );
   end

   // Hit decision on the selected entry
   always_comb begin
      hits_next = (sel_ff.hits == HITS_MAX) ? sel_ff.hits : sel_ff.hits + 1'b1;
      elapsed   = now_ff - sel_ff.last_time;
      burst     = {1'b0, hits_next} - {1'b0, sel_ff.at_last} + 1'b1;
      hit_full  = (elapsed >= {{(TIME_W-WINDOW_W){1'b0}}, window_ff}) ||
                  (burst >= {{(HITS_W+1-LIMIT_W){1'b0}}, limit_ff});
   end

   // Entry written at the front of the table
   always_comb begin
      front_entry.key = key_ff;
      if (hit_ff) begin
         front_entry.hits      = hits_next;
         front_entry.last_time = hit_full ? now_ff : sel_ff.last_time;
         front_entry.at_last   = hit_full ? hits_next : sel_ff.at_last;
      end else begin
         front_entry.hits      = HITS_W'(1);
         front_entry.last_time = now_ff;
         front_entry.at_last   = HITS_W'(1);
      end
   end

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      now_in       = now_ff;
      sel_in       = sel_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_full_in  = rsp_full_ff;

      // Drop the result once transferred
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               key_in   = req_key;
               now_in   = req_tdata[REQ_DATA_W-1:FAMILY_W+CODE_W+SITE_W];
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            sel_in   = sel_chain[0];
            hit_in   = seen_chain[0];
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (decide_go) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = front_entry.hits;
               rsp_full_in  = hit_ff ? hit_full : 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration writes
   assign csr_ready = 1'b1;
   always_comb begin
      window_in = window_ff;
      limit_in  = limit_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_REPEAT_WINDOW: window_in = csr_data;
            REG_BURST_LIMIT:   limit_in  = csr_data[LIMIT_W-1:0];
            default:           ;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         window_ff    <= WINDOW_RESET;
         limit_ff     <= LIMIT_RESET;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
         limit_ff     <= limit_in;
         hit_ff       <= hit_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      now_ff       <= now_in;
      sel_ff       <= sel_in;
      rsp_count_ff <= rsp_count_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_count_ff;
   assign rsp_tuser  = rsp_full_ff;

   // Tags stay unique, so at most one cell matches
   `LRUDT_ASSERT_ALWAYS(a_single_match, clock, reset, $onehot0(match_vec),
      "more than one table slot matched the tag")
   // Valid slots form a prefix from the front
   `LRUDT_ASSERT_ALWAYS(a_valid_prefix, clock, reset,
      ((valid_vec >> 1) & ~valid_vec) == '0, "gap in valid table slots")
   // After an update the front slot holds the event
   `LRUDT_ASSERT_NEXT(a_front_loaded, clock, reset, decide_go,
      valid_vec[0] && (entry_chain[0].key == $past(key_ff)),
      "front slot not loaded with the current tag")
   // A decide issues a result and returns the sequencer to idle
   `LRUDT_ASSERT_NEXT(a_result_issued, clock, reset, decide_go,
      rsp_valid_ff && (state_ff == ST_IDLE), "decide did not issue a result")
   // Table is empty coming out of reset
   `LRUDT_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), valid_vec == '0,
      "table not empty after reset")

endmodule
